// File: src/pfdr_pkg.sv
// shared types and constants of the page frame buffer with dirty-box refresh
package pfdr_pkg;

	// item kinds
	typedef enum logic [1:0] {
		KIND_DRAW    = 2'd0,
		KIND_READ    = 2'd1,
		KIND_CLEAR   = 2'd2,
		KIND_REFRESH = 2'd3
	} kind_t;

	// draw colours
	localparam logic [1:0] COLOR_CLEAR  = 2'd0;
	localparam logic [1:0] COLOR_SET    = 2'd1;
	localparam logic [1:0] COLOR_INVERT = 2'd2;

	// quarter turns of the logical coordinates
	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	// refresh stream phases
	localparam logic [1:0] PHASE_PAGE   = 2'd0;
	localparam logic [1:0] PHASE_COL_HI = 2'd1;
	localparam logic [1:0] PHASE_COL_LO = 2'd2;
	localparam logic [1:0] PHASE_DATA   = 2'd3;

	// panel command bytes
	localparam logic [7:0] CMD_PAGE   = 8'hB0;
	localparam logic [7:0] CMD_COL_HI = 8'h10;
	localparam logic [7:0] CMD_COL_LO = 8'h00;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic execute;
		logic sweep;
	} ctl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic sweep_end;
	} dp_status_t;

endpackage

// File: src/pfdr_ctrl.sv
// controller state machine: accept, execute and clearing sweep sequencing
module pfdr_ctrl
	import pfdr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] kind,
	input  dp_status_t status,
	output ctl_cmd_t   cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CLEAR
	} state_t;

	state_t state_q;
	logic   owe_q;

	// state and pending clear result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			owe_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (kind == KIND_CLEAR) begin
							state_q <= ST_CLEAR;
							owe_q   <= 1'b1;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				ST_CLEAR: begin
					if (status.sweep_end) begin
						state_q <= ST_IDLE;
						owe_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// commands to the datapath
	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && start;
		cmd.execute = (state_q == ST_EXEC);
		cmd.sweep   = (state_q == ST_CLEAR);
	end

	// handshake outputs
	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_EXEC) || ((state_q == ST_CLEAR) && status.sweep_end && owe_q);

endmodule

// File: src/pfdr_datapath.sv
// datapath: coordinate mapping, frame memory, dirty box and refresh stream
module pfdr_datapath
	import pfdr_pkg::*;
#(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctl_cmd_t           cmd,
	output dp_status_t         status,
	input  logic               rotation_we,
	input  logic [1:0]         rotation_wdata,
	input  logic [1:0]         kind,
	input  logic signed [15:0] x_coord,
	input  logic signed [15:0] y_coord,
	input  logic [1:0]         color,
	output logic               pixel_value,
	output logic [7:0]         stream_byte,
	output logic               is_data,
	output logic               byte_valid,
	output logic               last
);

	localparam int PAGE_COUNT = (PANEL_HEIGHT + 7) / 8;
	localparam int STORE_SIZE = PANEL_WIDTH * PAGE_COUNT;
	localparam int AW         = $clog2(STORE_SIZE);
	localparam int CW         = $clog2(PANEL_WIDTH);
	localparam int RW         = $clog2(PANEL_HEIGHT);

	// configuration, dirty box and refresh state
	logic [1:0]    rotation_q;
	logic [CW-1:0] col_min_q, col_max_q;
	logic [RW-1:0] row_min_q, row_max_q;
	logic          active_q;
	logic [2:0]    page_q;
	logic [CW-1:0] column_q;
	logic [1:0]    phase_q;
	logic [CW-1:0] span_first_q, span_last_q;
	logic [2:0]    span_last_page_q;
	logic [AW-1:0] sweep_q;

	logic [CW-1:0] col_min_d, col_max_d;
	logic [RW-1:0] row_min_d, row_max_d;
	logic          active_d;
	logic [2:0]    page_d;
	logic [CW-1:0] column_d;
	logic [1:0]    phase_d;
	logic [CW-1:0] span_first_d, span_last_d;
	logic [2:0]    span_last_page_d;
	logic [AW-1:0] sweep_d;

	// captured item
	logic [1:0]    kind_q;
	logic [1:0]    color_q;
	logic          hit_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] addr_q;

	// frame memory
	logic [7:0]    mem [STORE_SIZE];
	logic [7:0]    rdata_q;
	logic          wr_en;
	logic [7:0]    wr_data;
	logic [AW-1:0] rd_addr;

	// coordinate mapping
	logic signed [16:0] xs, ys, lw, lh, c_full, r_full;
	logic               loc_hit;
	logic [CW-1:0]      loc_col;
	logic [RW-1:0]      loc_row;
	logic [15:0]        loc_row_ext;
	logic [AW-1:0]      loc_addr;
	logic [AW-1:0]      ref_addr;

	// refresh helpers
	logic [15:0] rmin_ext, rmax_ext;
	logic [7:0]  first_ext;
	logic [7:0]  bit_mask;

	// rotate and bounds-check the logical coordinates
	always_comb begin
		xs = 17'(x_coord);
		ys = 17'(y_coord);
		lw = rotation_q[0] ? 17'(PANEL_HEIGHT) : 17'(PANEL_WIDTH);
		lh = rotation_q[0] ? 17'(PANEL_WIDTH) : 17'(PANEL_HEIGHT);
		loc_hit = (xs >= 17'sd0) && (xs < lw) && (ys >= 17'sd0) && (ys < lh);
		unique case (rotation_q)
			ROT_90: begin
				c_full = 17'(PANEL_WIDTH - 1) - ys;
				r_full = xs;
			end
			ROT_180: begin
				c_full = 17'(PANEL_WIDTH - 1) - xs;
				r_full = 17'(PANEL_HEIGHT - 1) - ys;
			end
			ROT_270: begin
				c_full = ys;
				r_full = 17'(PANEL_HEIGHT - 1) - xs;
			end
			default: begin
				c_full = xs;
				r_full = ys;
			end
		endcase
		loc_col     = c_full[CW-1:0];
		loc_row     = r_full[RW-1:0];
		loc_row_ext = 16'(loc_row);
		loc_addr    = AW'(loc_col) + AW'(loc_row_ext[5:3]) * AW'(PANEL_WIDTH);
	end

	// store address of the next refresh data byte
	assign ref_addr = AW'(column_q) + AW'(page_q) * AW'(PANEL_WIDTH);
	assign rd_addr  = (kind == KIND_REFRESH) ? ref_addr : loc_addr;

	// capture of the accepted item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			color_q <= color;
			hit_q   <= loc_hit;
			col_q   <= loc_col;
			row_q   <= loc_row;
			addr_q  <= loc_addr;
		end
	end

	// frame memory write port
	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			mem[sweep_q] <= '0;
		end else if (wr_en) begin
			mem[addr_q] <= wr_data;
		end
	end

	// frame memory read port
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// clear-item dirty marking, execute of draw, read and refresh beat, sweep address, next state
	always_comb begin
		col_min_d        = col_min_q;
		col_max_d        = col_max_q;
		row_min_d        = row_min_q;
		row_max_d        = row_max_q;
		active_d         = active_q;
		page_d           = page_q;
		column_d         = column_q;
		phase_d          = phase_q;
		span_first_d     = span_first_q;
		span_last_d      = span_last_q;
		span_last_page_d = span_last_page_q;
		sweep_d          = sweep_q;
		wr_en            = 1'b0;
		wr_data          = rdata_q;
		pixel_value      = 1'b0;
		stream_byte      = 8'h00;
		is_data          = 1'b0;
		byte_valid       = 1'b0;
		last             = 1'b0;
		rmin_ext         = 16'(row_min_q);
		rmax_ext         = 16'(row_max_q);
		first_ext        = 8'h00;
		bit_mask         = 8'h01 << row_q[2:0];

		// a clear item marks the whole panel dirty
		if (cmd.capture && (kind == KIND_CLEAR)) begin
			col_min_d = '0;
			col_max_d = CW'(PANEL_WIDTH - 1);
			row_min_d = '0;
			row_max_d = RW'(PANEL_HEIGHT - 1);
		end

		if (cmd.execute) begin
			unique case (kind_q)
				KIND_DRAW: begin
					if (hit_q) begin
						if (col_q < col_min_q) col_min_d = col_q;
						if (col_q > col_max_q) col_max_d = col_q;
						if (row_q < row_min_q) row_min_d = row_q;
						if (row_q > row_max_q) row_max_d = row_q;
						unique case (color_q)
							COLOR_CLEAR: begin
								wr_en   = 1'b1;
								wr_data = rdata_q & ~bit_mask;
							end
							COLOR_SET: begin
								wr_en   = 1'b1;
								wr_data = rdata_q | bit_mask;
							end
							COLOR_INVERT: begin
								wr_en   = 1'b1;
								wr_data = rdata_q ^ bit_mask;
							end
							default: begin
								wr_en = 1'b0;
							end
						endcase
					end
				end
				KIND_READ: begin
					pixel_value = hit_q & rdata_q[row_q[2:0]];
				end
				KIND_CLEAR: begin
					pixel_value = 1'b0;
				end
				KIND_REFRESH: begin
					// open a stream from the dirty box
					if (!active_q) begin
						if ((col_min_q > col_max_q) || (row_min_q > row_max_q)) begin
							last = 1'b1;
						end else begin
							span_first_d     = col_min_q;
							span_last_d      = col_max_q;
							page_d           = rmin_ext[5:3];
							span_last_page_d = rmax_ext[5:3];
							active_d         = 1'b1;
							phase_d          = PHASE_PAGE;
							col_min_d        = CW'(PANEL_WIDTH - 1);
							col_max_d        = '0;
							row_min_d        = RW'(PANEL_HEIGHT - 1);
							row_max_d        = '0;
						end
					end
					// emit one stream beat
					if (active_d) begin
						byte_valid = 1'b1;
						first_ext  = 8'(span_first_d);
						unique case (phase_d)
							PHASE_PAGE: begin
								stream_byte = CMD_PAGE | {5'd0, page_d};
								phase_d     = PHASE_COL_HI;
							end
							PHASE_COL_HI: begin
								stream_byte = CMD_COL_HI | {4'd0, first_ext[7:4]};
								phase_d     = PHASE_COL_LO;
							end
							PHASE_COL_LO: begin
								stream_byte = CMD_COL_LO | {4'd0, first_ext[3:0]};
								column_d    = span_first_d;
								phase_d     = PHASE_DATA;
							end
							default: begin
								is_data     = 1'b1;
								stream_byte = rdata_q;
								if (column_q >= span_last_q) begin
									phase_d = PHASE_PAGE;
									if (page_q >= span_last_page_q) begin
										last     = 1'b1;
										active_d = 1'b0;
									end else begin
										page_d = page_q + 3'd1;
									end
								end else begin
									column_d = column_q + CW'(1);
								end
							end
						endcase
					end
				end
				default: begin
					pixel_value = 1'b0;
				end
			endcase
		end

		// clearing sweep address
		if (cmd.sweep) begin
			sweep_d = status.sweep_end ? '0 : sweep_q + AW'(1);
		end
	end

	assign status.sweep_end = (sweep_q == AW'(STORE_SIZE - 1));

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q       <= ROT_0;
			col_min_q        <= '0;
			col_max_q        <= CW'(PANEL_WIDTH - 1);
			row_min_q        <= '0;
			row_max_q        <= RW'(PANEL_HEIGHT - 1);
			active_q         <= 1'b0;
			page_q           <= '0;
			column_q         <= '0;
			phase_q          <= PHASE_PAGE;
			span_first_q     <= '0;
			span_last_q      <= '0;
			span_last_page_q <= '0;
			sweep_q          <= '0;
		end else begin
			if (rotation_we) begin
				rotation_q <= rotation_wdata;
			end
			col_min_q        <= col_min_d;
			col_max_q        <= col_max_d;
			row_min_q        <= row_min_d;
			row_max_q        <= row_max_d;
			active_q         <= active_d;
			page_q           <= page_d;
			column_q         <= column_d;
			phase_q          <= phase_d;
			span_first_q     <= span_first_d;
			span_last_q      <= span_last_d;
			span_last_page_q <= span_last_page_d;
			sweep_q          <= sweep_d;
		end
	end

endmodule

// File: src/page_framebuffer_dirty_refresh.sv
// top level of the page frame buffer with dirty-box partial refresh
//
//   channel   handshake                 payload
//   ---------------------------------------------------------------------------
//   config    rotation_we               rotation_wdata
//   item in   start, busy               kind, x_coord, y_coord, color
//   result    done                      pixel_value, stream_byte, is_data,
//                                       byte_valid, last
//
// draw, read and refresh items: the accept cycle issues the frame memory read,
// the next cycle modifies and writes back or forms the beat and strobes done.
// a clear item holds busy for a one-byte-per-cycle clearing sweep of the whole
// frame memory, then strobes done. after reset the same sweep runs with busy
// high and no result. done is a one-cycle strobe; the receiver cannot stall.
module page_framebuffer_dirty_refresh
	import pfdr_pkg::*;
#(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rotation_we,
	input  logic [1:0]         rotation_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic signed [15:0] x_coord,
	input  logic signed [15:0] y_coord,
	input  logic [1:0]         color,
	output logic               done,
	output logic               pixel_value,
	output logic [7:0]         stream_byte,
	output logic               is_data,
	output logic               byte_valid,
	output logic               last
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	// sequencing
	pfdr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// frame store and refresh datapath
	pfdr_datapath #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.rotation_we    (rotation_we),
		.rotation_wdata (rotation_wdata),
		.kind           (kind),
		.x_coord        (x_coord),
		.y_coord        (y_coord),
		.color          (color),
		.pixel_value    (pixel_value),
		.stream_byte    (stream_byte),
		.is_data        (is_data),
		.byte_valid     (byte_valid),
		.last           (last)
	);

endmodule

// File: sim/page_framebuffer_dirty_refresh_tb.sv
// self-checking testbench of the page frame buffer with dirty-box partial refresh
`timescale 1ns / 1ps

module page_framebuffer_dirty_refresh_tb
	import pfdr_pkg::*;
;

	localparam int W           = 128;
	localparam int H           = 64;
	localparam int STORE_BYTES = W * ((H + 7) / 8);
	localparam int PHASES      = 8;
	localparam int RAND_ITEMS  = 1950;
	localparam int CYCLE_LIMIT = 10_000_000;

	// one result beat as the panel side sees it
	typedef struct packed {
		logic       pix;
		logic [7:0] sbyte;
		logic       data;
		logic       valid;
		logic       last;
	} beat_t;

	// one line of the directed stimulus
	typedef struct {
		logic [1:0] k;
		int         x;
		int         y;
		logic [1:0] c;
		bit         typed;
		beat_t      b;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               rotation_we;
	logic [1:0]         rotation_wdata;
	logic               start;
	logic               busy;
	logic [1:0]         kind;
	logic signed [15:0] x_coord;
	logic signed [15:0] y_coord;
	logic [1:0]         color;
	logic               done;
	logic               pixel_value;
	logic [7:0]         stream_byte;
	logic               is_data;
	logic               byte_valid;
	logic               last;

	page_framebuffer_dirty_refresh #(
		.PANEL_WIDTH (W),
		.PANEL_HEIGHT(H)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.rotation_we   (rotation_we),
		.rotation_wdata(rotation_wdata),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.x_coord       (x_coord),
		.y_coord       (y_coord),
		.color         (color),
		.done          (done),
		.pixel_value   (pixel_value),
		.stream_byte   (stream_byte),
		.is_data       (is_data),
		.byte_valid    (byte_valid),
		.last          (last)
	);

	// shadow copy of the frame store, dirty box and refresh walker
	logic [7:0] shadow_store [STORE_BYTES];
	logic [1:0] shadow_rot;
	int         box_cmin, box_cmax, box_rmin, box_rmax;
	bit         walk_active;
	logic [1:0] walk_phase;
	int         walk_page, walk_col, span_c0, span_c1, span_plast;

	beat_t      pending_beats [$];
	beat_t      last_beat;
	int         gap_pct;
	int         fail_count  = 0;
	int         cycle_count = 0;
	int         sent_items  = 0;
	int         n_draw = 0, n_read = 0, n_clear = 0, n_beats = 0, n_empty = 0, n_streams = 0;

	dir_row_t   dir_rows [32];
	int         n_dir = 0;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic beat_t mk_beat(logic p, logic [7:0] s, logic d, logic v, logic l);
		beat_t b;
		b.pix   = p;
		b.sbyte = s;
		b.data  = d;
		b.valid = v;
		b.last  = l;
		return b;
	endfunction

	// logical coordinates to panel column and row under the current rotation
	function automatic bit panel_pos(input int x, input int y, output int col, output int row);
		int lw, lh;
		lw  = shadow_rot[0] ? H : W;
		lh  = shadow_rot[0] ? W : H;
		col = 0;
		row = 0;
		if (x < 0 || x >= lw || y < 0 || y >= lh)
			return 1'b0;
		case (shadow_rot)
			ROT_90: begin
				col = W - 1 - y;
				row = x;
			end
			ROT_180: begin
				col = W - 1 - x;
				row = H - 1 - y;
			end
			ROT_270: begin
				col = y;
				row = H - 1 - x;
			end
			default: begin
				col = x;
				row = y;
			end
		endcase
		return 1'b1;
	endfunction

	task automatic box_whole();
		box_cmin = 0;
		box_cmax = W - 1;
		box_rmin = 0;
		box_rmax = H - 1;
	endtask

	// advance the shadow state by one item and form the beat it should produce
	task automatic shadow_step(input logic [1:0] k, input logic signed [15:0] xs,
		input logic signed [15:0] ys, input logic [1:0] c, output beat_t b);
		int col, row, idx;
		logic [7:0] m;
		b = '0;
		case (k)
			KIND_DRAW: begin
				if (panel_pos(int'(xs), int'(ys), col, row)) begin
					idx = col + (row >> 3) * W;
					m   = 8'(1 << (row & 7));
					if (col < box_cmin) box_cmin = col;
					if (col > box_cmax) box_cmax = col;
					if (row < box_rmin) box_rmin = row;
					if (row > box_rmax) box_rmax = row;
					case (c)
						COLOR_CLEAR:  shadow_store[idx] = shadow_store[idx] & ~m;
						COLOR_SET:    shadow_store[idx] = shadow_store[idx] | m;
						COLOR_INVERT: shadow_store[idx] = shadow_store[idx] ^ m;
						default: ;
					endcase
				end
			end
			KIND_READ: begin
				if (panel_pos(int'(xs), int'(ys), col, row))
					b.pix = shadow_store[col + (row >> 3) * W][row & 7];
			end
			KIND_CLEAR: begin
				for (int i = 0; i < STORE_BYTES; i++)
					shadow_store[i] = 8'h00;
				box_whole();
			end
			default: begin
				// latch the box at the start of a stream, empty box gives a bare last
				if (!walk_active) begin
					if (box_cmin > box_cmax || box_rmin > box_rmax) begin
						b.last = 1'b1;
					end else begin
						span_c0     = box_cmin;
						span_c1     = box_cmax;
						walk_page   = box_rmin >> 3;
						span_plast  = box_rmax >> 3;
						walk_active = 1'b1;
						walk_phase  = PHASE_PAGE;
						box_cmin    = W - 1;
						box_cmax    = 0;
						box_rmin    = H - 1;
						box_rmax    = 0;
					end
				end
				if (walk_active) begin
					b.valid = 1'b1;
					case (walk_phase)
						PHASE_PAGE: begin
							b.sbyte    = CMD_PAGE | 8'(walk_page);
							walk_phase = PHASE_COL_HI;
						end
						PHASE_COL_HI: begin
							b.sbyte    = CMD_COL_HI | 8'(span_c0 >> 4);
							walk_phase = PHASE_COL_LO;
						end
						PHASE_COL_LO: begin
							b.sbyte    = CMD_COL_LO | 8'(span_c0 & 15);
							walk_col   = span_c0;
							walk_phase = PHASE_DATA;
						end
						default: begin
							b.data  = 1'b1;
							b.sbyte = shadow_store[walk_col + walk_page * W];
							if (walk_col >= span_c1) begin
								walk_phase = PHASE_PAGE;
								if (walk_page >= span_plast) begin
									b.last      = 1'b1;
									walk_active = 1'b0;
								end else begin
									walk_page = (walk_page + 1) & 7;
								end
							end else begin
								walk_col = (walk_col + 1) & 127;
							end
						end
					endcase
				end
			end
		endcase
	endtask

	// offer one item, wait for it to be taken, queue what it should produce
	task automatic send_item(input logic [1:0] k, input int xv, input int yv, input logic [1:0] c,
		input bit typed, input beat_t typed_b);
		logic signed [15:0] xs, ys;
		beat_t b;
		xs = 16'(xv);
		ys = 16'(yv);
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		kind    <= k;
		x_coord <= xs;
		y_coord <= ys;
		color   <= c;
		do @(posedge clk); while (busy);
		shadow_step(k, xs, ys, c, b);
		pending_beats.push_back(typed ? typed_b : b);
		last_beat  = b;
		sent_items = sent_items + 1;
		case (k)
			KIND_DRAW:  n_draw++;
			KIND_READ:  n_read++;
			KIND_CLEAR: n_clear++;
			default: begin
				if (b.valid) n_beats++;
				else n_empty++;
				if (b.valid && b.last) n_streams++;
			end
		endcase
	endtask

	task automatic send_refresh();
		send_item(KIND_REFRESH, int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
			2'($urandom_range(0, 3)), 1'b0, '0);
	endtask

	// let every outstanding beat arrive, then write the rotation register
	task automatic write_rotation(input logic [1:0] v);
		start <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		while (busy) @(posedge clk);
		rotation_we    <= 1'b1;
		rotation_wdata <= v;
		@(posedge clk);
		shadow_rot = v;
		rotation_we <= 1'b0;
	endtask

	task automatic add_row(input logic [1:0] k, input int x, input int y, input logic [1:0] c,
		input bit typed, input beat_t b);
		dir_rows[n_dir].k     = k;
		dir_rows[n_dir].x     = x;
		dir_rows[n_dir].y     = y;
		dir_rows[n_dir].c     = c;
		dir_rows[n_dir].typed = typed;
		dir_rows[n_dir].b     = b;
		n_dir++;
	endtask

	// a short run of draws and reads around one spot, with some strays off-screen
	task automatic draw_burst();
		int lw, lh, cx, cy, n, sel, x, y;
		logic [1:0] k;
		lw = shadow_rot[0] ? H : W;
		lh = shadow_rot[0] ? W : H;
		cx = $urandom_range(0, lw - 1);
		cy = $urandom_range(0, lh - 1);
		n  = $urandom_range(1, 12);
		repeat (n) begin
			sel = $urandom_range(0, 99);
			k   = (sel < 55 || (sel >= 85 && sel < 89)) ? KIND_DRAW : KIND_READ;
			if (sel < 85) begin
				x = cx + int'($urandom_range(0, 6)) - 3;
				y = cy + int'($urandom_range(0, 6)) - 3;
			end else if (sel < 93) begin
				x = $urandom_range(0, lw - 1);
				y = $urandom_range(0, lh - 1);
			end else begin
				x = $urandom_range(0, lw - 1);
				y = $urandom_range(0, lh - 1);
				case ($urandom_range(0, 5))
					0: x = -1;
					1: x = lw;
					2: y = -1;
					3: y = lh;
					4: x = $urandom_range(0, 1) ? -32768 : 32767;
					default: begin
						x = int'($urandom_range(0, 65535));
						y = int'($urandom_range(0, 65535));
					end
				endcase
			end
			send_item(k, x, y, 2'($urandom_range(0, 3)), 1'b0, '0);
		end
	endtask

	// refresh beats until the stream ends or the run runs out, then one more if it ended
	task automatic refresh_run();
		int n;
		bit ended;
		n     = $urandom_range(1, 40);
		ended = 1'b0;
		for (int i = 0; i < n && !ended; i++) begin
			send_refresh();
			ended = last_beat.valid && last_beat.last;
		end
		if (ended)
			send_refresh();
	endtask

	// result checker
	always @(posedge clk) begin
		beat_t e;
		if (arst_n && done) begin
			if (pending_beats.size() == 0) begin
				$error("result beat with nothing expected");
				fail_count++;
			end else begin
				e = pending_beats.pop_front();
				if (pixel_value !== e.pix) begin
					$error("pixel_value: expected %0h, got %0h", e.pix, pixel_value);
					fail_count++;
				end
				if (stream_byte !== e.sbyte) begin
					$error("stream_byte: expected %0h, got %0h", e.sbyte, stream_byte);
					fail_count++;
				end
				if (is_data !== e.data) begin
					$error("is_data: expected %0h, got %0h", e.data, is_data);
					fail_count++;
				end
				if (byte_valid !== e.valid) begin
					$error("byte_valid: expected %0h, got %0h", e.valid, byte_valid);
					fail_count++;
				end
				if (last !== e.last) begin
					$error("last: expected %0h, got %0h", e.last, last);
					fail_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		int per_phase, target, sel;
		beat_t z;
		z = '0;

		arst_n         <= 1'b0;
		rotation_we    <= 1'b0;
		rotation_wdata <= ROT_0;
		start          <= 1'b0;
		kind           <= KIND_DRAW;
		x_coord        <= '0;
		y_coord        <= '0;
		color          <= COLOR_CLEAR;
		gap_pct         = 0;

		// shadow reset state
		for (int i = 0; i < STORE_BYTES; i++)
			shadow_store[i] = 8'h00;
		shadow_rot  = ROT_0;
		box_whole();
		walk_active = 1'b0;
		walk_phase  = PHASE_PAGE;
		walk_page   = 0;
		walk_col    = 0;
		span_c0     = 0;
		span_c1     = 0;
		span_plast  = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_rotation(ROT_0);

		// directed rows: corners, off-screen, ignored colour, first stream, clear mid-stream
		add_row(KIND_READ,    0,      0,      COLOR_SET,    1'b1, z);
		add_row(KIND_DRAW,    0,      0,      COLOR_SET,    1'b1, z);
		add_row(KIND_READ,    0,      0,      COLOR_CLEAR,  1'b1,
			mk_beat(1'b1, 8'h00, 1'b0, 1'b0, 1'b0));
		add_row(KIND_DRAW,    W - 1,  H - 1,  COLOR_SET,    1'b1, z);
		add_row(KIND_READ,    W - 1,  H - 1,  COLOR_CLEAR,  1'b1,
			mk_beat(1'b1, 8'h00, 1'b0, 1'b0, 1'b0));
		add_row(KIND_DRAW,    W - 1,  H - 1,  COLOR_INVERT, 1'b1, z);
		add_row(KIND_READ,    W - 1,  H - 1,  COLOR_CLEAR,  1'b1, z);
		add_row(KIND_DRAW,    5,      5,      2'd3,         1'b1, z);
		add_row(KIND_READ,    5,      5,      COLOR_CLEAR,  1'b1, z);
		add_row(KIND_READ,    -1,     0,      COLOR_CLEAR,  1'b1, z);
		add_row(KIND_READ,    W,      0,      COLOR_CLEAR,  1'b1, z);
		add_row(KIND_READ,    0,      H,      COLOR_CLEAR,  1'b1, z);
		add_row(KIND_DRAW,    32767,  -32768, COLOR_SET,    1'b1, z);
		add_row(KIND_DRAW,    -32768, 32767,  COLOR_INVERT, 1'b1, z);
		add_row(KIND_REFRESH, 0,      0,      COLOR_CLEAR,  1'b1,
			mk_beat(1'b0, CMD_PAGE, 1'b0, 1'b1, 1'b0));
		add_row(KIND_REFRESH, -1,     -1,     2'd3,         1'b1,
			mk_beat(1'b0, CMD_COL_HI, 1'b0, 1'b1, 1'b0));
		add_row(KIND_REFRESH, 0,      0,      COLOR_CLEAR,  1'b1,
			mk_beat(1'b0, CMD_COL_LO, 1'b0, 1'b1, 1'b0));
		add_row(KIND_REFRESH, 0,      0,      COLOR_CLEAR,  1'b1,
			mk_beat(1'b0, 8'h01, 1'b1, 1'b1, 1'b0));
		add_row(KIND_REFRESH, 0,      0,      COLOR_CLEAR,  1'b0, z);
		add_row(KIND_CLEAR,   -32768, -32768, 2'd3,         1'b1, z);
		add_row(KIND_READ,    0,      0,      COLOR_CLEAR,  1'b1, z);
		add_row(KIND_REFRESH, 0,      0,      COLOR_CLEAR,  1'b0, z);
		add_row(KIND_DRAW,    3,      9,      COLOR_SET,    1'b0, z);
		add_row(KIND_READ,    3,      9,      COLOR_CLEAR,  1'b0, z);
		add_row(KIND_DRAW,    3,      9,      COLOR_CLEAR,  1'b0, z);
		for (int i = 0; i < n_dir; i++)
			send_item(dir_rows[i].k, dir_rows[i].x, dir_rows[i].y, dir_rows[i].c,
				dir_rows[i].typed, dir_rows[i].b);

		// random phases with rotation and sender gaps varied per phase
		per_phase = RAND_ITEMS / PHASES;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: write_rotation(ROT_270);
				1: write_rotation(ROT_90);
				2: write_rotation(ROT_180);
				3: write_rotation(ROT_0);
				4: write_rotation(ROT_270);
				5: write_rotation(ROT_0);
				default: write_rotation(2'($urandom_range(0, 3)));
			endcase
			// results cannot be held off, so only the sender idles
			case (ph % 4)
				1:       gap_pct = 49;
				3:       gap_pct = 7;
				default: gap_pct = 0;
			endcase
			target = sent_items + per_phase;
			while (sent_items < target) begin
				sel = $urandom_range(0, 99);
				if (sel < 50) begin
					draw_burst();
				end else if (sel < 78) begin
					refresh_run();
				end else if (sel < 92) begin
					repeat ($urandom_range(1, 4)) send_refresh();
				end else if (sel < 99) begin
					// noise: any kind but clear, any field value
					repeat ($urandom_range(1, 3)) begin
						case ($urandom_range(0, 2))
							0:       send_item(KIND_DRAW,
								int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
								2'($urandom_range(0, 3)), 1'b0, '0);
							1:       send_item(KIND_READ,
								int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
								2'($urandom_range(0, 3)), 1'b0, '0);
							default: send_refresh();
						endcase
					end
				end else begin
					send_item(KIND_CLEAR, int'($urandom_range(0, 65535)),
						int'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)), 1'b0, '0);
				end
			end
		end

		// drain
		start <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d items: %0d draws, %0d reads, %0d clears, %0d refresh bytes",
			sent_items, n_draw, n_read, n_clear, n_beats);
		$display("refresh streams completed: %0d, refresh requests on a clean panel: %0d",
			n_streams, n_empty);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: files.f
src/pfdr_pkg.sv
src/pfdr_ctrl.sv
src/pfdr_datapath.sv
src/page_framebuffer_dirty_refresh.sv
sim/page_framebuffer_dirty_refresh_tb.sv
